@@ rtl/lde_pkg.sv @@
`default_nettype none
package lde_pkg;

    localparam int MAX_ENGINES = 16;

    // field and register widths
    localparam int LEN_W   = 32;
    localparam int OFF_W   = 32;
    localparam int ADDR_W  = 48;
    localparam int ENG_W   = 4;
    localparam int ME_W    = 5;
    localparam int EB_W    = 7;
    localparam int CL_W    = 9;
    localparam int MC_W    = 21;
    localparam int CFG_W   = 21;
    localparam int CFGI_W  = 3;

    // internal widths
    localparam int N_W     = $clog2(MAX_ENGINES + 1);
    localparam int ACC_W   = MC_W + N_W;
    localparam int BYTES_W = 36;
    localparam int DIV_W   = 40;
    localparam int DVS_W   = 9;
    localparam int REM_W   = $clog2(MAX_ENGINES * 512);
    localparam int REME_W  = REM_W + 3;
    localparam int SLE_W   = 33;
    localparam int BITS_W  = 41;
    localparam int RB_W    = 48;
    localparam int RE_W    = 40;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_MAX_ENGINES = 3'd0;
    localparam logic [CFGI_W-1:0] CFG_ELEM_BITS   = 3'd1;
    localparam logic [CFGI_W-1:0] CFG_LINE_BYTES  = 3'd2;
    localparam logic [CFGI_W-1:0] CFG_MIN_CHUNK   = 3'd3;
    localparam logic [CFGI_W-1:0] CFG_BROADCAST   = 3'd4;

    // divider operand selection
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_BYTES_N  = 2'd0;
    localparam t_sel SEL_SLICE_CL = 2'd1;
    localparam t_sel SEL_SLICE_EB = 2'd2;
    localparam t_sel SEL_REM_EB   = 2'd3;

    typedef struct packed {
        logic [LEN_W-1:0]  length_elements;
        logic [OFF_W-1:0]  node_offset;
        logic              has_source;
        logic [ADDR_W-1:0] src_address;
        logic [OFF_W-1:0]  src_elem_offset;
        logic [ADDR_W-1:0] dst_address;
        logic [OFF_W-1:0]  dst_elem_offset;
    } t_in_item;

    typedef struct packed {
        logic [ENG_W-1:0]  engine_number;
        logic [LEN_W-1:0]  slice_elements;
        logic [OFF_W-1:0]  slice_node_offset;
        logic [ADDR_W-1:0] slice_src_address;
        logic [OFF_W-1:0]  slice_src_offset;
        logic [ADDR_W-1:0] slice_dst_address;
        logic [OFF_W-1:0]  slice_dst_offset;
        logic              last_slice;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic count;
        logic div_start;
        logic div_take;
        t_sel sel;
        logic prep1;
        logic prep2;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic count_more;
        logic div_done;
        logic last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

@@ rtl/lde_in_if.sv @@
`default_nettype none
interface lde_in_if;
    import lde_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/lde_out_if.sv @@
`default_nettype none
interface lde_out_if;
    import lde_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/lde_div.sv @@
`default_nettype none
module lde_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [lde_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [lde_pkg::DVS_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [lde_pkg::DIV_W-1:0]      o_quot,
    output logic [lde_pkg::DVS_W-1:0]      o_rem
);
    import lde_pkg::*;

    localparam int STEPS = DIV_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   w_t1;
    logic [DVS_W:0]   w_t2;
    logic             w_q1;
    logic             w_q2;
    logic [DVS_W-1:0] w_r1;
    logic [DVS_W-1:0] w_r2;

    // two restoring steps per cycle
    always_comb begin
        w_t1 = {r_rem, r_num[DIV_W-1]};
        w_q1 = (w_t1 >= {1'b0, r_dvs});
        w_r1 = w_q1 ? DVS_W'(w_t1 - {1'b0, r_dvs}) : w_t1[DVS_W-1:0];
        w_t2 = {w_r1, r_num[DIV_W-2]};
        w_q2 = (w_t2 >= {1'b0, r_dvs});
        w_r2 = w_q2 ? DVS_W'(w_t2 - {1'b0, r_dvs}) : w_t2[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= CNT_W'(STEPS - 1);
        end else if (r_busy) begin
            r_num <= r_num << 2;
            r_quo <= {r_quo[DIV_W-3:0], w_q1, w_q2};
            r_rem <= w_r2;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

@@ rtl/lde_ctrl.sv @@
`default_nettype none
module lde_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire lde_pkg::t_stat i_stat,
    output lde_pkg::t_cmd       o_cmd
);
    import lde_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_COUNT = 3'd1;
    localparam logic [2:0] S_DGO   = 3'd2;
    localparam logic [2:0] S_DWAIT = 3'd3;
    localparam logic [2:0] S_PREP1 = 3'd4;
    localparam logic [2:0] S_PREP2 = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_sel       r_sel;
    t_sel       n_sel;

    always_comb begin
        n_state    = r_state;
        n_sel      = r_sel;
        o_cmd      = '0;
        o_cmd.sel  = r_sel;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_COUNT;
                end
            end
            S_COUNT: begin
                if (i_stat.count_more) begin
                    o_cmd.count = 1'b1;
                end else begin
                    n_sel   = SEL_BYTES_N;
                    n_state = S_DGO;
                end
            end
            S_DGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_take = 1'b1;
                    case (r_sel)
                        SEL_BYTES_N:  begin n_sel = SEL_SLICE_CL; n_state = S_DGO; end
                        SEL_SLICE_CL: begin n_sel = SEL_SLICE_EB; n_state = S_DGO; end
                        SEL_SLICE_EB: begin n_sel = SEL_REM_EB;   n_state = S_DGO; end
                        default:      n_state = S_PREP1;
                    endcase
                end
            end
            S_PREP1: begin
                o_cmd.prep1 = 1'b1;
                n_state     = S_PREP2;
            end
            S_PREP2: begin
                o_cmd.prep2 = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                // one slice per free output slot
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_BYTES_N;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end
endmodule
`default_nettype wire

@@ rtl/lde_dp.sv @@
`default_nettype none
module lde_dp (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [lde_pkg::CFGI_W-1:0] i_cfg_index,
    input  wire logic [lde_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire lde_pkg::t_in_item          i_item,
    input  wire lde_pkg::t_cmd              i_cmd,
    output lde_pkg::t_stat                  o_stat,
    lde_out_if.source                       o_out
);
    import lde_pkg::*;

    // configuration
    logic [ME_W-1:0] r_max_eng;
    logic [EB_W-1:0] r_elem_bits;
    logic [CL_W-1:0] r_line;
    logic [MC_W-1:0] r_min_chunk;
    logic            r_bcast;

    logic [N_W-1:0]  w_me;
    logic [EB_W-1:0] w_eb;
    logic [CL_W-1:0] w_cl;
    logic [MC_W-1:0] w_mc;

    // transfer
    logic [OFF_W-1:0]   r_node;
    logic               r_has_src;
    logic [ADDR_W-1:0]  r_src_addr;
    logic [OFF_W-1:0]   r_src_off;
    logic [ADDR_W-1:0]  r_dst_addr;
    logic [OFF_W-1:0]   r_dst_off;
    logic [BYTES_W-1:0] r_bytes;
    logic [N_W-1:0]     r_n;
    logic [ACC_W-1:0]   r_acc;
    logic [BYTES_W-1:0] r_slice;
    logic [REM_W-1:0]   r_rem;
    logic [SLE_W-1:0]   r_slice_e;
    logic [REME_W-1:0]  r_rem_e;
    logic [SLE_W-1:0]   r_last_e;
    logic [BITS_W-1:0]  r_slice_bits;
    logic [BITS_W-1:0]  r_last_bits;
    logic [N_W-1:0]     r_working;
    logic [N_W-1:0]     r_idx;
    logic [OFF_W-1:0]   r_done;
    logic [BITS_W-1:0]  r_done_bits;

    // carried across transfers
    logic [RB_W-1:0] r_run_b;
    logic [RE_W-1:0] r_run_e;

    logic      r_out_valid;
    t_out_item r_out;

    logic [LEN_W+EB_W-1:0] w_prod;
    logic [BYTES_W-1:0]    w_bytes;
    logic [DIV_W-1:0]      w_dividend;
    logic [DVS_W-1:0]      w_divisor;
    logic                  w_div_done;
    logic [DIV_W-1:0]      w_quot;
    logic [DVS_W-1:0]      w_drem;
    logic [REM_W-1:0]      w_line_fill;
    logic                  w_last;
    logic [SLE_W-1:0]      w_sz;
    logic [BITS_W-1:0]     w_bits;
    logic [RB_W-1:0]       w_sz_bytes;
    logic [ADDR_W-1:0]     w_done_bytes;

    assign w_eb = (r_elem_bits == '0) ? EB_W'(1) : r_elem_bits;
    assign w_cl = (r_line == '0) ? CL_W'(1) : r_line;
    assign w_mc = (r_min_chunk == '0) ? MC_W'(1) : r_min_chunk;

    always_comb begin
        if (r_max_eng == '0) begin
            w_me = N_W'(1);
        end else if (32'(r_max_eng) > MAX_ENGINES) begin
            w_me = N_W'(MAX_ENGINES);
        end else begin
            w_me = N_W'(r_max_eng);
        end
    end

    assign w_prod  = (LEN_W+EB_W)'(i_item.length_elements) * (LEN_W+EB_W)'(w_eb);
    assign w_bytes = BYTES_W'(({1'b0, w_prod} + (LEN_W+EB_W+1)'(7)) >> 3);

    always_comb begin
        case (i_cmd.sel)
            SEL_BYTES_N: begin
                w_dividend = DIV_W'(r_bytes);
                w_divisor  = DVS_W'(r_n);
            end
            SEL_SLICE_CL: begin
                w_dividend = DIV_W'(r_slice);
                w_divisor  = DVS_W'(w_cl);
            end
            SEL_SLICE_EB: begin
                w_dividend = DIV_W'({r_slice, 3'b000});
                w_divisor  = DVS_W'(w_eb);
            end
            default: begin
                w_dividend = DIV_W'({r_rem, 3'b000});
                w_divisor  = DVS_W'(w_eb);
            end
        endcase
    end

    lde_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_drem)
    );

    // line remainder of each engine moves to the last one
    assign w_line_fill = REM_W'(REM_W'(w_drem) * REM_W'(r_n));

    assign w_last       = (r_idx == r_working - N_W'(1));
    assign w_sz         = w_last ? r_last_e : r_slice_e;
    assign w_bits       = w_last ? r_last_bits : r_slice_bits;
    assign w_sz_bytes   = RB_W'(({1'b0, w_bits} + (BITS_W+1)'(7)) >> 3);
    assign w_done_bytes = ADDR_W'(({1'b0, r_done_bits} + (BITS_W+1)'(7)) >> 3);

    assign o_stat.count_more = (r_n < w_me)
                             && (BYTES_W'(r_acc) + BYTES_W'(w_mc) <= r_bytes);
    assign o_stat.div_done   = w_div_done;
    assign o_stat.last       = w_last;
    assign o_stat.out_free   = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_eng   <= ME_W'(1);
            r_elem_bits <= EB_W'(8);
            r_line      <= CL_W'(128);
            r_min_chunk <= MC_W'(1024);
            r_bcast     <= 1'b0;
            r_run_b     <= '0;
            r_run_e     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_ENGINES: r_max_eng   <= i_cfg_data[ME_W-1:0];
                    CFG_ELEM_BITS:   r_elem_bits <= i_cfg_data[EB_W-1:0];
                    CFG_LINE_BYTES:  r_line      <= i_cfg_data[CL_W-1:0];
                    CFG_MIN_CHUNK:   r_min_chunk <= i_cfg_data[MC_W-1:0];
                    CFG_BROADCAST:   r_bcast     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.emit) begin
                r_run_b     <= r_run_b + w_sz_bytes;
                r_run_e     <= r_run_e + RE_W'(w_sz);
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_node     <= i_item.node_offset;
            r_has_src  <= i_item.has_source;
            r_src_addr <= i_item.src_address;
            r_src_off  <= i_item.src_elem_offset;
            r_dst_addr <= i_item.dst_address;
            r_dst_off  <= i_item.dst_elem_offset;
            r_bytes    <= w_bytes;
            r_n        <= N_W'(1);
            r_acc      <= ACC_W'(w_mc);
        end
        if (i_cmd.count) begin
            r_n   <= r_n + N_W'(1);
            r_acc <= r_acc + ACC_W'(w_mc);
        end
        if (i_cmd.div_take) begin
            case (i_cmd.sel)
                SEL_BYTES_N: begin
                    r_slice <= BYTES_W'(w_quot);
                    r_rem   <= REM_W'(w_drem);
                end
                SEL_SLICE_CL: begin
                    r_slice <= r_slice - BYTES_W'(w_drem);
                    r_rem   <= r_rem + w_line_fill;
                end
                SEL_SLICE_EB: r_slice_e <= SLE_W'(w_quot);
                default:      r_rem_e   <= REME_W'(w_quot);
            endcase
        end
        if (i_cmd.prep1) begin
            r_last_e     <= r_slice_e + SLE_W'(r_rem_e);
            r_slice_bits <= BITS_W'(BITS_W'(r_slice_e) * BITS_W'(w_eb));
            r_working    <= (r_slice_e == '0) ? N_W'(1) : r_n;
            r_idx        <= '0;
            r_done       <= '0;
            r_done_bits  <= '0;
        end
        if (i_cmd.prep2) begin
            r_last_bits <= BITS_W'(BITS_W'(r_last_e) * BITS_W'(w_eb));
        end
        if (i_cmd.emit) begin
            r_out.engine_number     <= ENG_W'(r_idx);
            r_out.slice_elements    <= LEN_W'(w_sz);
            r_out.slice_node_offset <= r_node + OFF_W'(r_run_e);
            if (!r_has_src) begin
                r_out.slice_src_address <= '0;
                r_out.slice_src_offset  <= '0;
            end else if (r_bcast) begin
                r_out.slice_src_address <= r_src_addr + w_done_bytes;
                r_out.slice_src_offset  <= r_done;
            end else begin
                r_out.slice_src_address <= r_src_addr + ADDR_W'(r_run_b);
                r_out.slice_src_offset  <= r_src_off + OFF_W'(r_run_e);
            end
            r_out.slice_dst_address <= r_dst_addr + ADDR_W'(r_run_b);
            r_out.slice_dst_offset  <= r_dst_off + OFF_W'(r_run_e);
            r_out.last_slice        <= w_last;
            r_idx                   <= r_idx + N_W'(1);
            r_done                  <= r_done + OFF_W'(w_sz);
            r_done_bits             <= r_done_bits + w_bits;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
endmodule
`default_nettype wire

@@ rtl/linear_dma_engine_split.sv @@
// Linear DMA transfer splitter.
// i_in carries one transfer per beat (valid/ready); o_out carries one beat per
// engine slice, in engine order, with last_slice set on the final one.
// i_cfg_we/i_cfg_index/i_cfg_data write the five setup registers; write them
// only while no transfer is in flight.
// Per transfer: accept in S_IDLE, then S_COUNT sizes the engine count (one
// add and compare per cycle, up to MAX_ENGINES engines), then four divisions
// on one shared radix-4 restoring divider, then the prep states S_PREP1 and
// S_PREP2, then one slice per cycle while o_out has a free slot.
// The first slice is registered onto o_out from S_EMIT, after the prep states.
// The next transfer is accepted in the cycle after the last slice is loaded,
// even while that slice still waits on o_out.
// A stall on o_out holds the pending slice and pauses slice generation.
// Reset (synchronous, active low) restores the register defaults, clears the
// running byte and element offsets and drops any transfer in progress.
`default_nettype none
module linear_dma_engine_split (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [lde_pkg::CFGI_W-1:0] i_cfg_index,
    input  wire logic [lde_pkg::CFG_W-1:0]  i_cfg_data,
    lde_in_if.sink                          i_in,
    lde_out_if.source                       o_out
);
    import lde_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    lde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lde_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in.data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out       (o_out)
    );

    assign i_in.ready = w_in_ready;
endmodule
`default_nettype wire

@@ rtl/lde_checker.sv @@
`default_nettype none
module lde_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire lde_pkg::t_out_item i_out_data
);
    import lde_pkg::*;

    // reset empties the output slot
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // one transfer at a time: no back-to-back accepts
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted twice in a row");

    // a slice that is not the last one means the transfer is still open
    a_no_accept_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_data.last_slice |-> !i_in_ready)
        else $error("input ready before the last slice");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output beat changed");
endmodule

bind linear_dma_engine_split lde_checker u_lde_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
`default_nettype wire

@@ verif/tb_linear_dma_engine_split.sv @@
`default_nettype none
module tb_linear_dma_engine_split;
    import lde_pkg::*;

    // index with no register behind it; writes must change nothing
    localparam logic [CFGI_W-1:0] CFG_NO_REG = 3'd7;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFGI_W-1:0] i_cfg_index;
    logic [CFG_W-1:0] i_cfg_data;

    lde_in_if  in_if ();
    lde_out_if out_if ();

    linear_dma_engine_split DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always #4 i_clk = ~i_clk;

    // splitter settings and carried offsets as the block should hold them
    logic [ME_W-1:0]  eng_limit;
    logic [EB_W-1:0]  elem_bits;
    logic [CL_W-1:0]  line_bytes;
    logic [MC_W-1:0]  chunk_min;
    logic             bcast_mode;
    logic [RB_W-1:0]  carried_bytes;
    logic [RE_W-1:0]  carried_elems;

    t_out_item pending_slices[$];
    t_out_item slice_want;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatch_count;
    int slices_checked;
    int transfers_sent;
    int reg_writes;

    function automatic logic [63:0] bytes_for(input logic [63:0] elems,
                                              input logic [63:0] bits);
        return (elems * bits + 64'd7) / 64'd8;
    endfunction

    // work out every slice one transfer produces and advance the carried offsets
    function automatic void split_transfer(input t_in_item t);
        logic [63:0] eb, cl, mc, me, total, n, slice, rem, rem_e, slice_e, working, done, sz;
        t_out_item s;
        eb = (elem_bits == 0) ? 64'd1 : 64'(elem_bits);
        cl = (line_bytes == 0) ? 64'd1 : 64'(line_bytes);
        mc = (chunk_min == 0) ? 64'd1 : 64'(chunk_min);
        me = (eng_limit == 0) ? 64'd1 : 64'(eng_limit);
        if (me > 64'(MAX_ENGINES))
            me = 64'(MAX_ENGINES);
        total = bytes_for(64'(t.length_elements), eb);
        n = total / mc;
        if (n > me)
            n = me;
        if (n == 0)
            n = 64'd1;
        slice = total / n;
        rem = total % n;
        rem = rem + (slice % cl) * n;
        slice = slice - (slice % cl);
        rem_e = (64'd8 * rem) / eb;
        slice_e = (64'd8 * slice) / eb;
        working = (slice_e == 0) ? 64'd1 : n;
        done = 64'd0;
        for (int i = 0; i < working; i++) begin
            sz = slice_e + ((i == working - 1) ? rem_e : 64'd0);
            s.engine_number = ENG_W'(i);
            s.slice_elements = sz[LEN_W-1:0];
            s.slice_node_offset = t.node_offset + carried_elems[OFF_W-1:0];
            if (!t.has_source) begin
                s.slice_src_address = '0;
                s.slice_src_offset = '0;
            end else if (bcast_mode) begin
                s.slice_src_address = t.src_address + ADDR_W'(bytes_for(done, eb));
                s.slice_src_offset = done[OFF_W-1:0];
            end else begin
                s.slice_src_address = t.src_address + carried_bytes;
                s.slice_src_offset = t.src_elem_offset + carried_elems[OFF_W-1:0];
            end
            s.slice_dst_address = t.dst_address + carried_bytes;
            s.slice_dst_offset = t.dst_elem_offset + carried_elems[OFF_W-1:0];
            s.last_slice = (i == working - 1);
            carried_bytes = carried_bytes + RB_W'(bytes_for(sz, eb));
            carried_elems = carried_elems + RE_W'(sz);
            done = done + sz;
            pending_slices = {pending_slices, s};
        end
    endfunction

    task automatic flag(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
            flag($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
    endtask

    // check each slice beat against the oldest one predicted
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (pending_slices.size() == 0) begin
                flag($sformatf("slice beat with nothing predicted: 0x%0h", out_if.data));
            end else begin
                slice_want = pending_slices.pop_front();
                slices_checked++;
                compare_field("engine_number", 64'(slice_want.engine_number),
                              64'(out_if.data.engine_number));
                compare_field("slice_elements", 64'(slice_want.slice_elements),
                              64'(out_if.data.slice_elements));
                compare_field("slice_node_offset", 64'(slice_want.slice_node_offset),
                              64'(out_if.data.slice_node_offset));
                compare_field("slice_src_address", 64'(slice_want.slice_src_address),
                              64'(out_if.data.slice_src_address));
                compare_field("slice_src_offset", 64'(slice_want.slice_src_offset),
                              64'(out_if.data.slice_src_offset));
                compare_field("slice_dst_address", 64'(slice_want.slice_dst_address),
                              64'(out_if.data.slice_dst_address));
                compare_field("slice_dst_offset", 64'(slice_want.slice_dst_offset),
                              64'(out_if.data.slice_dst_offset));
                compare_field("last_slice", 64'(slice_want.last_slice),
                              64'(out_if.data.last_slice));
            end
        end
    end

    // receiver: stall at random at the current rate
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        #(8 * TIMEOUT_CYCLES);
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_transfer(input t_in_item t);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.data = t;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        split_transfer(t);
        transfers_sent++;
    endtask

    // hold off the sender until every predicted slice has come back
    task automatic drain();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (pending_slices.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        reg_writes++;
        case (idx)
            CFG_MAX_ENGINES: eng_limit = val[ME_W-1:0];
            CFG_ELEM_BITS:   elem_bits = val[EB_W-1:0];
            CFG_LINE_BYTES:  line_bytes = val[CL_W-1:0];
            CFG_MIN_CHUNK:   chunk_min = val[MC_W-1:0];
            CFG_BROADCAST:   bcast_mode = val[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] me, input logic [CFG_W-1:0] eb,
                            input logic [CFG_W-1:0] cl, input logic [CFG_W-1:0] mc,
                            input logic [CFG_W-1:0] bc);
        drain();
        write_reg(CFG_MAX_ENGINES, me);
        write_reg(CFG_ELEM_BITS, eb);
        write_reg(CFG_LINE_BYTES, cl);
        write_reg(CFG_MIN_CHUNK, mc);
        write_reg(CFG_BROADCAST, bc);
    endtask

    function automatic t_in_item make_item(input logic [LEN_W-1:0] len,
                                           input logic [OFF_W-1:0] node,
                                           input logic has_src,
                                           input logic [ADDR_W-1:0] src,
                                           input logic [OFF_W-1:0] src_off,
                                           input logic [ADDR_W-1:0] dst,
                                           input logic [OFF_W-1:0] dst_off);
        t_in_item t;
        t.length_elements = len;
        t.node_offset = node;
        t.has_source = has_src;
        t.src_address = src;
        t.src_elem_offset = src_off;
        t.dst_address = dst;
        t.dst_elem_offset = dst_off;
        return t;
    endfunction

    function automatic logic [OFF_W-1:0] random_offset();
        case ($urandom_range(3))
            0: return '0;
            1: return '1 - OFF_W'($urandom_range(0, 64));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item random_transfer();
        logic [LEN_W-1:0] len;
        case ($urandom_range(9))
            0, 1, 2, 3: len = $urandom_range(1, 4096);
            4, 5, 6:    len = $urandom_range(1, 1 << 20);
            7, 8:       len = ($urandom == 0) ? 32'd1 : $urandom;
            default:    len = $urandom_range(1, 64);
        endcase
        return make_item(len, random_offset(), 1'($urandom_range(1)),
                         ADDR_W'({$urandom, $urandom}), random_offset(),
                         ADDR_W'({$urandom, $urandom}), random_offset());
    endfunction

    task automatic test_reset_defaults();
        // zero length, no source side, then every field at its top value
        send_transfer(make_item(32'd0, 32'd5, 1'b1, 48'h1000, 32'd7, 48'h2000, 32'd9));
        send_transfer(make_item(32'd1000, 32'd0, 1'b0, '1, '1, 48'd0, 32'd0));
        send_transfer(make_item('1, '1, 1'b1, '1, '1, '1, '1));
    endtask

    task automatic test_engine_split();
        set_regs(21'd4, 21'd8, 21'd64, 21'd256, 21'd0);
        send_transfer(make_item(32'd4096, 32'd100, 1'b1, 48'h10_0000, 32'd3, 48'h20_0000, 32'd4));
        send_transfer(make_item(32'd1000, 32'd0, 1'b1, 48'h30_0000, 32'd0, 48'h40_0000, 32'd0));
        // slice rounds to nothing, so one engine takes it all
        drain();
        write_reg(CFG_MIN_CHUNK, 21'd1);
        write_reg(CFG_LINE_BYTES, 21'd128);
        send_transfer(make_item(32'd100, 32'd1, 1'b1, 48'h50, 32'd2, 48'h60, 32'd3));
    endtask

    task automatic test_broadcast();
        send_idle_pct = 31;
        recv_stall_pct = 31;
        set_regs(21'd16, 21'd12, 21'd1, 21'd1, 21'd1);
        send_transfer(make_item(32'd1000, 32'd0, 1'b1, 48'hABC0, 32'd11, 48'hDEF0, 32'd22));
        send_transfer(make_item(32'd1600, '1, 1'b1, '1, 32'd0, '1, '1));
        send_transfer(make_item(32'd1000, 32'd7, 1'b0, 48'h1234, 32'd5, 48'h5678, 32'd6));
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_register_extremes();
        // zeros in the engine, element, line and chunk registers read as one
        set_regs(21'd0, 21'd0, 21'd0, 21'd0, 21'd0);
        send_transfer(make_item(32'd5000, 32'd1, 1'b1, 48'd0, 32'd0, 48'd0, 32'd0));
        // engine count saturates at the top, widest element and line
        set_regs(21'd31, 21'd127, 21'd511, 21'd1, 21'd0);
        send_transfer(make_item('1, 32'd2, 1'b1, 48'h8000_0000_0000, 32'd0, 48'h1, 32'd0));
        send_transfer(make_item(32'd1600, 32'd3, 1'b1, 48'h100, 32'd1, 48'h200, 32'd2));
        set_regs(21'd16, 21'd64, 21'd256, 21'h1F_FFFF, 21'd1);
        send_transfer(make_item('1, 32'd4, 1'b1, 48'h7FFF_FFFF_FFFF, 32'd9, 48'd0, 32'd0));
        send_transfer(make_item(32'd10, 32'd5, 1'b1, 48'h40, 32'd0, 48'h80, 32'd0));
        set_regs(21'd16, 21'd1, 21'd1, 21'd1048576, 21'd1);
        send_transfer(make_item('1, 32'd6, 1'b1, 48'h0, 32'd0, 48'h0, 32'd0));
        // upper data bits beyond each register are dropped
        set_regs(21'h1FFFE2, 21'h1FFF88, 21'h1FFE40, 21'd64, 21'h1FFFFE);
        drain();
        write_reg(CFG_NO_REG, '1);
        send_transfer(make_item(32'd9000, 32'd7, 1'b1, 48'h1000, 32'd1, 48'h2000, 32'd2));
        send_transfer(make_item(32'd9000, 32'd8, 1'b0, '1, '1, '1, '1));
    endtask

    task automatic randomize_regs();
        logic [CFG_W-1:0] me, eb, cl, mc, bc, noise;
        me = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(0, 31))
                                      : CFG_W'($urandom_range(1, 16));
        case ($urandom_range(3))
            0: eb = CFG_W'(8);
            1: eb = CFG_W'(1 << $urandom_range(0, 6));
            default: eb = CFG_W'($urandom_range(0, 127));
        endcase
        cl = ($urandom_range(1) == 0) ? CFG_W'(1 << $urandom_range(0, 8))
                                      : CFG_W'($urandom_range(0, 511));
        mc = ($urandom_range(2) == 0) ? CFG_W'($urandom_range(0, 21'h1F_FFFF))
                                      : CFG_W'($urandom_range(0, 4096));
        bc = CFG_W'($urandom_range(1));
        noise = ($urandom_range(1) == 0) ? CFG_W'($urandom) : '0;
        set_regs((noise & ~21'h1F) | me, (noise & ~21'h7F) | eb, (noise & ~21'h1FF) | cl,
                 mc, (noise & ~21'h1) | bc);
    endtask

    task automatic test_random_traffic();
        int phase;
        int setting;
        int k;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (setting = 0; setting < 6; setting++) begin
                randomize_regs();
                for (k = 0; k < 10; k++)
                    send_transfer(random_transfer());
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_MAX_ENGINES;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        slices_checked = 0;
        transfers_sent = 0;
        reg_writes = 0;
        eng_limit = 5'd1;
        elem_bits = 7'd8;
        line_bytes = 9'd128;
        chunk_min = 21'd1024;
        bcast_mode = 1'b0;
        carried_bytes = '0;
        carried_elems = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_engine_split();
        test_broadcast();
        test_register_extremes();
        test_random_traffic();

        drain();
        repeat (200) @(posedge i_clk);
        if (pending_slices.size() != 0)
            flag($sformatf("%0d slices never arrived", pending_slices.size()));

        $display("Covered %0d transfers split into %0d slices across %0d register writes,",
                 transfers_sent, slices_checked, reg_writes);
        $display("with sender gaps and receiver stalls alone, together and absent; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
